[design/drlm_pkg.sv]
// Shared types, codes and constants of the damage rectangle list.
package drlm_pkg;

    localparam int DEF_CAPACITY    = 16;
    localparam int DEF_COORD_WIDTH = 16;
    localparam int MAX_OUT         = 16;
    localparam int FIELD_W         = 16;
    localparam int CNT_OUT_W       = 5;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        STAT_ADDED    = 3'd0,
        STAT_SKIPPED  = 3'd1,
        STAT_OVERFLOW = 3'd2,
        STAT_CLEARED  = 3'd3,
        STAT_READOUT  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_FINISH
    } t_state;

    typedef struct packed {
        t_opcode                    opcode;
        logic signed [FIELD_W-1:0]  rect_left;
        logic signed [FIELD_W-1:0]  rect_top;
        logic signed [FIELD_W-1:0]  rect_right;
        logic signed [FIELD_W-1:0]  rect_bottom;
    } t_cmd;

    typedef struct packed {
        t_status                    status;
        logic [CNT_OUT_W-1:0]       removed_count;
        logic [CNT_OUT_W-1:0]       entry_count;
        logic                       entry_valid;
        logic signed [FIELD_W-1:0]  out_left;
        logic signed [FIELD_W-1:0]  out_top;
        logic signed [FIELD_W-1:0]  out_right;
        logic signed [FIELD_W-1:0]  out_bottom;
        logic                       last_result;
    } t_result;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

    typedef struct packed {
        logic a_covers_b;
        logic b_covers_a;
        logic same;
    } t_cmp_res;

    function automatic t_result mk_result(t_status st, logic [CNT_OUT_W-1:0] rem,
                                          logic [CNT_OUT_W-1:0] cnt, logic last);
        t_result r;
        r               = '0;
        r.status        = st;
        r.removed_count = rem;
        r.entry_count   = cnt;
        r.last_result   = last;
        return r;
    endfunction

endpackage

[design/drlm_cell.sv]
// One storage cell of the rectangle chain: loads a broadcast entry or takes its neighbor's.
module drlm_cell #(
    parameter int DATA_WIDTH = 4 * drlm_pkg::DEF_COORD_WIDTH
) (
    input  logic                    i_clk,
    input  drlm_pkg::t_cell_ctl     i_ctl,
    input  logic [DATA_WIDTH-1:0]   i_load_data,
    input  logic [DATA_WIDTH-1:0]   i_next,
    output logic [DATA_WIDTH-1:0]   o_data
);

    logic [DATA_WIDTH-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_data <= i_load_data;
        end else if (i_ctl.shift) begin
            r_data <= i_next;
        end
    end

    assign o_data = r_data;

endmodule

[design/drlm_cmp.sv]
// Containment and equality compare of two rectangles (left, top, right, bottom).
module drlm_cmp #(
    parameter int COORD_WIDTH = drlm_pkg::DEF_COORD_WIDTH
) (
    input  logic [4*COORD_WIDTH-1:0] i_a,
    input  logic [4*COORD_WIDTH-1:0] i_b,
    output drlm_pkg::t_cmp_res       o_res
);

    logic signed [COORD_WIDTH-1:0] w_al, w_at, w_ar, w_ab;
    logic signed [COORD_WIDTH-1:0] w_bl, w_bt, w_br, w_bb;
    logic w_a_empty, w_b_empty, w_a_le, w_b_le;

    assign w_al = i_a[COORD_WIDTH-1:0];
    assign w_at = i_a[2*COORD_WIDTH-1:COORD_WIDTH];
    assign w_ar = i_a[3*COORD_WIDTH-1:2*COORD_WIDTH];
    assign w_ab = i_a[4*COORD_WIDTH-1:3*COORD_WIDTH];
    assign w_bl = i_b[COORD_WIDTH-1:0];
    assign w_bt = i_b[2*COORD_WIDTH-1:COORD_WIDTH];
    assign w_br = i_b[3*COORD_WIDTH-1:2*COORD_WIDTH];
    assign w_bb = i_b[4*COORD_WIDTH-1:3*COORD_WIDTH];

    assign w_a_empty = (w_al >= w_ar) || (w_at >= w_ab);
    assign w_b_empty = (w_bl >= w_br) || (w_bt >= w_bb);

    // a inside b / b inside a, edges only
    assign w_a_le = (w_bl <= w_al) && (w_bt <= w_at) && (w_br >= w_ar) && (w_bb >= w_ab);
    assign w_b_le = (w_al <= w_bl) && (w_at <= w_bt) && (w_ar >= w_br) && (w_ab >= w_bb);

    always_comb begin
        o_res.a_covers_b = !w_a_empty && !w_b_empty && w_b_le;
        o_res.b_covers_a = !w_a_empty && !w_b_empty && w_a_le;
        o_res.same       = (i_a == i_b);
    end

endmodule

[design/damage_rect_list_merge_top.sv]
// Damage rectangle list: add with merge, clear and read-out over a rotating chain of cells.
// Add: busy to scan each stored entry and finish, result strobe in the first cycle busy is low.
// Read-out: busy while the entries rotate once, one result per cycle for up to 16 entries;
// results are registered from S_READ; if 16 or fewer, the last is in the first cycle busy is low.
// Clear, empty read-out: result in the next cycle, busy stays low; the receiver cannot stall.
// Synchronous active-low reset empties the list; cell contents are not cleared.
module damage_rect_list_merge_top #(
    parameter int CAPACITY    = drlm_pkg::DEF_CAPACITY,
    parameter int COORD_WIDTH = drlm_pkg::DEF_COORD_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  drlm_pkg::t_cmd    i_cmd,
    output logic              o_result_strobe,
    output drlm_pkg::t_result o_result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int DW    = 4 * COORD_WIDTH;
    localparam int XW    = (COORD_WIDTH > drlm_pkg::FIELD_W) ? COORD_WIDTH : drlm_pkg::FIELD_W;
    localparam int READ_LIM = (CAPACITY < drlm_pkg::MAX_OUT) ? CAPACITY : drlm_pkg::MAX_OUT;

    drlm_pkg::t_state  r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_occ, n_occ;
    logic [CNT_W-1:0]  r_step, n_step;
    logic [CNT_W-1:0]  r_removed, n_removed;
    logic              r_skip, n_skip;
    logic              r_nochk, n_nochk;
    logic [DW-1:0]     r_nb, n_nb;
    logic              r_strobe, n_strobe;
    drlm_pkg::t_result r_result, n_result;

    logic [DW-1:0]       w_cell_data [CAPACITY];
    drlm_pkg::t_cell_ctl w_cell_ctl  [CAPACITY];
    logic [DW-1:0]       w_head;
    logic [DW-1:0]       w_nb_in;
    logic [DW-1:0]       w_load_data;
    logic                w_shift, w_load;
    logic [IDX_W-1:0]    w_load_idx;
    drlm_pkg::t_cmp_res  w_cmp;
    logic                w_rm, w_cv, w_scan_last, w_read_last;
    logic [XW-1:0]       w_in_ext  [4];
    logic [XW-1:0]       w_out_ext [4];
    logic [drlm_pkg::FIELD_W-1:0] w_in_f [4];
    int unsigned         w_read_n;

    // input coordinates, zero-extended or truncated to COORD_WIDTH
    assign w_in_f[0] = i_cmd.rect_left;
    assign w_in_f[1] = i_cmd.rect_top;
    assign w_in_f[2] = i_cmd.rect_right;
    assign w_in_f[3] = i_cmd.rect_bottom;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_in_ext[k] = XW'($unsigned(w_in_f[k]));
            w_nb_in[k*COORD_WIDTH +: COORD_WIDTH] = w_in_ext[k][COORD_WIDTH-1:0];
            w_out_ext[k] = XW'($signed(w_head[k*COORD_WIDTH +: COORD_WIDTH]));
        end
    end

    // cell chain, cell 0 is the head
    assign w_head = w_cell_data[0];

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [DW-1:0] w_next;
        if (k == CAPACITY - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_cell_data[k+1];
        end

        always_comb begin
            w_cell_ctl[k].shift = w_shift;
            w_cell_ctl[k].load  = w_load && (w_load_idx == IDX_W'(k));
        end

        drlm_cell #(
            .DATA_WIDTH (DW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_cell_ctl[k]),
            .i_load_data (w_load_data),
            .i_next      (w_next),
            .o_data      (w_cell_data[k])
        );
    end

    drlm_cmp #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cmp (
        .i_a   (r_nb),
        .i_b   (w_head),
        .o_res (w_cmp)
    );

    assign w_rm        = !r_skip && !w_cmp.same && w_cmp.a_covers_b;
    assign w_cv        = !r_skip && !r_nochk && w_cmp.b_covers_a;
    assign w_scan_last = (r_step == r_count - CNT_W'(1));
    assign w_read_n    = (32'(r_count) < 32'(READ_LIM)) ? 32'(r_count) : 32'(READ_LIM);
    assign w_read_last = (32'(r_step) + 32'd1 == w_read_n);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_occ       = r_occ;
        n_step      = r_step;
        n_removed   = r_removed;
        n_skip      = r_skip;
        n_nochk     = r_nochk;
        n_nb        = r_nb;
        n_strobe    = 1'b0;
        n_result    = r_result;
        w_shift     = 1'b0;
        w_load      = 1'b0;
        w_load_idx  = '0;
        w_load_data = w_head;

        unique case (r_state)
            drlm_pkg::S_IDLE: begin
                if (start) begin
                    unique case (i_cmd.opcode)
                        drlm_pkg::OP_ADD: begin
                            n_nb      = w_nb_in;
                            n_occ     = r_count;
                            n_step    = '0;
                            n_removed = '0;
                            n_skip    = 1'b0;
                            n_nochk   = 1'b0;
                            n_state   = (r_count == '0) ? drlm_pkg::S_FINISH
                                                        : drlm_pkg::S_SCAN;
                        end
                        drlm_pkg::OP_CLEAR: begin
                            n_count  = '0;
                            n_strobe = 1'b1;
                            n_result = drlm_pkg::mk_result(drlm_pkg::STAT_CLEARED, '0, '0, 1'b1);
                        end
                        drlm_pkg::OP_READ: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_result = drlm_pkg::mk_result(drlm_pkg::STAT_READOUT, '0,
                                               drlm_pkg::CNT_OUT_W'(r_count), 1'b1);
                            end else begin
                                n_step  = '0;
                                n_state = drlm_pkg::S_READ;
                            end
                        end
                        drlm_pkg::OP_NONE: begin
                        end
                    endcase
                end
            end

            drlm_pkg::S_SCAN: begin
                // pop head; survivors re-enter behind the unscanned entries
                w_shift = 1'b1;
                if (w_rm) begin
                    n_occ     = r_occ - CNT_W'(1);
                    n_removed = r_removed + CNT_W'(1);
                    n_nochk   = 1'b1;
                end else begin
                    w_load     = 1'b1;
                    w_load_idx = IDX_W'(r_occ - CNT_W'(1));
                end
                if (w_cv) begin
                    n_skip = 1'b1;
                end
                n_step = r_step + CNT_W'(1);
                if (w_scan_last) begin
                    n_state = drlm_pkg::S_FINISH;
                end
            end

            drlm_pkg::S_READ: begin
                w_shift    = 1'b1;
                w_load     = 1'b1;
                w_load_idx = IDX_W'(r_count - CNT_W'(1));
                if (32'(r_step) < w_read_n) begin
                    n_strobe = 1'b1;
                    n_result = drlm_pkg::mk_result(drlm_pkg::STAT_READOUT, '0,
                                   drlm_pkg::CNT_OUT_W'(r_count), w_read_last);
                    n_result.entry_valid = 1'b1;
                    n_result.out_left    = w_out_ext[0][drlm_pkg::FIELD_W-1:0];
                    n_result.out_top     = w_out_ext[1][drlm_pkg::FIELD_W-1:0];
                    n_result.out_right   = w_out_ext[2][drlm_pkg::FIELD_W-1:0];
                    n_result.out_bottom  = w_out_ext[3][drlm_pkg::FIELD_W-1:0];
                end
                n_step = r_step + CNT_W'(1);
                if (w_scan_last) begin
                    n_state = drlm_pkg::S_IDLE;
                end
            end

            drlm_pkg::S_FINISH: begin
                n_state  = drlm_pkg::S_IDLE;
                n_strobe = 1'b1;
                priority if (r_skip) begin
                    n_result = drlm_pkg::mk_result(drlm_pkg::STAT_SKIPPED, '0,
                                   drlm_pkg::CNT_OUT_W'(r_count), 1'b1);
                end else if (32'(r_occ) >= 32'(CAPACITY)) begin
                    n_count  = r_occ;
                    n_result = drlm_pkg::mk_result(drlm_pkg::STAT_OVERFLOW,
                                   drlm_pkg::CNT_OUT_W'(r_removed),
                                   drlm_pkg::CNT_OUT_W'(r_occ), 1'b1);
                end else begin
                    w_load      = 1'b1;
                    w_load_idx  = IDX_W'(r_occ);
                    w_load_data = r_nb;
                    n_count     = r_occ + CNT_W'(1);
                    n_result    = drlm_pkg::mk_result(drlm_pkg::STAT_ADDED,
                                      drlm_pkg::CNT_OUT_W'(r_removed),
                                      drlm_pkg::CNT_OUT_W'(r_occ + CNT_W'(1)), 1'b1);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= drlm_pkg::S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_occ     <= n_occ;
        r_step    <= n_step;
        r_removed <= n_removed;
        r_skip    <= n_skip;
        r_nochk   <= n_nochk;
        r_nb      <= n_nb;
        r_result  <= n_result;
    end

    assign busy            = (r_state != drlm_pkg::S_IDLE);
    assign o_result_strobe = r_strobe;
    assign o_result        = r_result;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(CAPACITY))
        else $error("entry count above capacity");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.opcode == drlm_pkg::OP_CLEAR) |=>
        (o_result_strobe && o_result.status == drlm_pkg::STAT_CLEARED &&
         o_result.entry_count == '0 && o_result.last_result))
        else $error("clear did not report");

    a_unused_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.opcode == drlm_pkg::OP_NONE) |=> !o_result_strobe)
        else $error("unused opcode produced a result");

    a_scan_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == drlm_pkg::S_SCAN) |->
        (r_occ <= r_count && r_occ != '0 && r_step < r_count))
        else $error("scan occupancy out of range");
`endif

endmodule
